>>> src/tcp_connection_state_tracker_top_assert.svh
// ----------------------------------------------------------------------------
// TCP connection state tracker assertion macros
// Property shorthands for the port checker, sampled on clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef TCP_CONNECTION_STATE_TRACKER_TOP_ASSERT_SVH
`define TCP_CONNECTION_STATE_TRACKER_TOP_ASSERT_SVH

// same-cycle implication
`define TCST_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TCST_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/tcst_pkg.sv
// ----------------------------------------------------------------------------
// TCP connection state tracker package
// State codes, flag masks, beat types and the half-connection next-state rule.
// ----------------------------------------------------------------------------
package tcst_pkg;

	localparam int TICK_COUNT_BITS = 32;
	localparam int STATE_W         = 4;
	localparam int AGE_W           = 32;
	localparam int TWT_W           = 16;

	typedef logic [STATE_W-1:0]         state_t;
	typedef logic [TICK_COUNT_BITS-1:0] tick_t;
	typedef logic [7:0]                 flags_t;

	localparam state_t ST_CLOSED       = 4'd0;
	localparam state_t ST_SYN_SENT     = 4'd1;
	localparam state_t ST_SYN_RECEIVED = 4'd2;
	localparam state_t ST_ESTABLISHED  = 4'd3;
	localparam state_t ST_FIN_WAIT_1   = 4'd4;
	localparam state_t ST_FIN_WAIT_2   = 4'd5;
	localparam state_t ST_CLOSE_WAIT   = 4'd6;
	localparam state_t ST_LAST_ACK     = 4'd7;
	localparam state_t ST_TIME_WAIT    = 4'd8;

	localparam int F_FIN_BIT = 0;
	localparam int F_SYN_BIT = 1;
	localparam int F_RST_BIT = 2;
	localparam int F_ACK_BIT = 4;

	localparam flags_t FLAGS_SYN = 8'h02;
	localparam flags_t FLAGS_ACK = 8'h10;

	localparam logic CMD_SEGMENT = 1'b0;
	localparam logic CMD_TICK    = 1'b1;

	localparam logic [TWT_W-1:0] TWT_RESET = 16'd60;

	typedef struct packed {
		logic   command;
		flags_t tcp_flags;
		logic   from_client;
	} in_item_t;

	typedef struct packed {
		state_t             client_state;
		state_t             server_state;
		state_t             shown_state;
		logic [AGE_W-1:0]   client_age;
		logic               clean_up;
	} result_t;

	function automatic state_t next_state(state_t cur, flags_t fl, logic client);
		state_t ns;
		ns = cur;
		if (fl[F_RST_BIT])
			ns = ST_CLOSED;
		else if (fl == FLAGS_SYN)
			ns = ST_SYN_SENT;
		else if (fl[F_SYN_BIT] && fl[F_ACK_BIT])
			ns = ST_SYN_RECEIVED;
		else if (cur == ST_SYN_RECEIVED && fl == FLAGS_ACK)
			ns = ST_ESTABLISHED;
		else if (cur == ST_ESTABLISHED && fl[F_FIN_BIT])
			ns = client ? ST_FIN_WAIT_1 : ST_CLOSE_WAIT;
		else if (cur == ST_FIN_WAIT_1 && fl[F_ACK_BIT])
			ns = ST_FIN_WAIT_2;
		else if (cur == ST_CLOSE_WAIT && fl[F_FIN_BIT])
			ns = ST_LAST_ACK;
		else if (cur == ST_FIN_WAIT_2 && fl[F_ACK_BIT])
			ns = ST_TIME_WAIT;
		else if (cur == ST_LAST_ACK && fl[F_ACK_BIT])
			ns = ST_CLOSED;
		return ns;
	endfunction

	function automatic tick_t sat_inc(tick_t v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

endpackage

>>> src/tcp_connection_state_tracker_top.sv
// ----------------------------------------------------------------------------
// TCP connection state tracker
// Follows one TCP connection as client and server half-state machines. Each
// input beat (segment or one time tick) gives exactly one result beat. A beat
// passes an input register and the tracking logic into a result register, and
// one beat is taken every clock as long as the result side keeps up; the state
// and counter update of one beat is registered as the beat enters the result
// register. The clean-up idle limit (reset 60) is written through the
// cfg channel, which is always ready; write it only while no beat is in flight.
// ----------------------------------------------------------------------------
module tcp_connection_state_tracker_top import tcst_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [TWT_W-1:0] cfg_data,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             command,
	input  logic [7:0]       tcp_flags,
	input  logic             from_client,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [3:0]       client_state,
	output logic [3:0]       server_state,
	output logic [3:0]       shown_state,
	output logic [31:0]      client_age,
	output logic             clean_up
);

	logic [TWT_W-1:0] twt_q;
	in_item_t         in_item, item_s1;
	logic             valid_s1, advance;
	result_t          res, res_s2;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			twt_q <= TWT_RESET;
		end else if (cfg_valid) begin
			twt_q <= cfg_data;
		end
	end

	assign in_item.command     = command;
	assign in_item.tcp_flags   = tcp_flags;
	assign in_item.from_client = from_client;

	tcst_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	tcst_track u_track (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item_s1 (item_s1),
		.twt     (twt_q),
		.res     (res)
	);

	tcst_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.advance   (advance),
		.res       (res),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res_s2    (res_s2)
	);

	assign client_state = res_s2.client_state;
	assign server_state = res_s2.server_state;
	assign shown_state  = res_s2.shown_state;
	assign client_age   = res_s2.client_age;
	assign clean_up     = res_s2.clean_up;

endmodule

>>> src/tcst_in_stage.sv
// ----------------------------------------------------------------------------
// Input register
// Captures one input beat; holds it until the tracking stage takes it.
// ----------------------------------------------------------------------------
module tcst_in_stage import tcst_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  in_item_t in_item,
	input  logic     advance,
	output logic     valid_s1,
	output in_item_t item_s1
);

	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

endmodule

>>> src/tcst_track.sv
// ----------------------------------------------------------------------------
// Connection tracking stage
// Holds both half states and the tick counters; forms the result of a beat.
// ----------------------------------------------------------------------------
module tcst_track import tcst_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  in_item_t         item_s1,
	input  logic [TWT_W-1:0] twt,
	output result_t          res
);

	state_t client_q, server_q;
	tick_t  idle_q, age_q;

	state_t      client_d, server_d, ns;
	tick_t       idle_d, age_d;
	logic [63:0] idle_ext, age_ext;
	logic        both_closed, any_tw;

	always_comb begin
		client_d = client_q;
		server_d = server_q;
		idle_d   = idle_q;
		age_d    = age_q;
		ns       = next_state(item_s1.from_client ? client_q : server_q,
			item_s1.tcp_flags, item_s1.from_client);
		if (item_s1.command == CMD_TICK) begin
			idle_d = sat_inc(idle_q);
			age_d  = sat_inc(age_q);
		end else if (item_s1.from_client) begin
			if (ns != client_q) begin
				client_d = ns;
				idle_d   = '0;
				age_d    = '0;
			end
		end else begin
			if (ns != server_q) begin
				server_d = ns;
				idle_d   = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			client_q <= ST_CLOSED;
			server_q <= ST_CLOSED;
			idle_q   <= '0;
			age_q    <= '0;
		end else if (advance) begin
			client_q <= client_d;
			server_q <= server_d;
			idle_q   <= idle_d;
			age_q    <= age_d;
		end
	end

	assign idle_ext    = 64'(idle_d);
	assign age_ext     = 64'(age_d);
	assign both_closed = (client_d == ST_CLOSED) && (server_d == ST_CLOSED);
	assign any_tw      = (client_d == ST_TIME_WAIT) || (server_d == ST_TIME_WAIT);

	always_comb begin
		res.client_state = client_d;
		res.server_state = server_d;
		res.shown_state  = (client_d != ST_CLOSED) ? client_d : server_d;
		res.client_age   = (age_ext > 64'h0000_0000_FFFF_FFFF) ? '1 : age_ext[AGE_W-1:0];
		res.clean_up     = both_closed || (any_tw && (idle_ext >= 64'(twt)));
	end

endmodule

>>> src/tcst_out_stage.sv
// ----------------------------------------------------------------------------
// Result register
// Holds one result beat until the consumer takes it.
// ----------------------------------------------------------------------------
module tcst_out_stage import tcst_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    valid_s1,
	output logic    advance,
	input  result_t res,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t res_s2
);

	logic valid_s2;

	assign advance   = valid_s1 && (!valid_s2 || out_ready);
	assign out_valid = valid_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

endmodule

>>> src/tcst_checker.sv
// ----------------------------------------------------------------------------
// TCP connection state tracker port checker
// Watches the top-level ports for result consistency and output stalls.
// ----------------------------------------------------------------------------
`include "tcp_connection_state_tracker_top_assert.svh"

module tcst_checker import tcst_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             out_valid,
	input logic             out_ready,
	input logic [3:0]       client_state,
	input logic [3:0]       server_state,
	input logic [3:0]       shown_state,
	input logic [31:0]      client_age,
	input logic             clean_up
);

	`TCST_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(client_age) && $stable(shown_state) && $stable(clean_up), "result beat changed while stalled")

	`TCST_ASSERT_NOW(a_shown, out_valid, shown_state == ((client_state != ST_CLOSED) ? client_state : server_state), "shown_state does not follow the half states")

	`TCST_ASSERT_NOW(a_clean_closed, out_valid && client_state == ST_CLOSED && server_state == ST_CLOSED, clean_up, "both halves closed without clean_up")

	`TCST_ASSERT_NOW(a_clean_why, out_valid && clean_up, (client_state == ST_CLOSED && server_state == ST_CLOSED) || client_state == ST_TIME_WAIT || server_state == ST_TIME_WAIT, "clean_up outside closed or timed-wait state")

endmodule

bind tcp_connection_state_tracker_top tcst_checker u_tcst_checker (.*);
